>>> rtl/bde_pkg.sv
package bde_pkg;

   localparam logic [15:0] DEFAULT_DEBOUNCE = 16'd2;
   localparam logic [7:0]  LONG_REPEAT      = 8'd1;
   localparam logic [7:0]  HOLD_RESTART     = 8'd50;
   localparam logic [7:0]  HOLD_TOP         = 8'hFF;

   localparam int unsigned CSR_ADDR_WIDTH = 4;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_TRIGGER_LEVEL  = 2'd0;
   localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd1;
   localparam logic [1:0] REG_LONG_TICKS     = 2'd2;
   localparam logic [1:0] REG_LONG_ENABLED   = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_PRESSED  = 2'd1,
      PH_RELEASED = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_PRESS = 2'd1,
      EV_LONG  = 2'd2
   } event_type;

   typedef struct packed {
      logic      up_event;
      logic      click_event;
      logic      long_event;
      logic      long_release_event;
      phase_type button_phase;
      event_type last_event;
   } rsp_type;

endpackage

>>> rtl/bde_rsp_queue.sv
module bde_rsp_queue
   import bde_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(DEPTH);

   rsp_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 push, pop;

   assign in_stall  = (count_ff == (PTR_W+1)'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> rtl/button_debounce_event_detector.sv
// Debounced push-button event detector.
// Input channel (req_*): one transaction per sampling tick, carrying the
// sampled pin level. Result channel (rsp_*): exactly one transaction per
// input tick, carrying the up / click / long / long-release flags, the phase
// and the last event code after that tick.
// A result is written into the result queue when its input is accepted.
// Throughput: one tick per clock cycle while req_stall is low; the state
// update is a single pass of counter increments and compares between the
// state registers and a two-entry result queue.
// When the receiver stalls, results wait in the queue; input keeps being
// accepted until both entries are full, then req_stall rises until a result
// is taken.
// Reset (synchronous, active high) clears all but queue data, sets the stable
// level to 1 (inverse of the reset trigger level) and empties the queue.
// Configuration (APB-style, always ready) is meant to be written only when
// no results are pending; writing trigger_level also reloads the stable level.
module button_debounce_event_detector
   import bde_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_level,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_up_event,
   output logic                      rsp_click_event,
   output logic                      rsp_long_event,
   output logic                      rsp_long_release_event,
   output logic [1:0]                rsp_button_phase,
   output logic [1:0]                rsp_last_event,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic        trigger_ff;
   logic [15:0] deb_ticks_ff;
   logic [15:0] long_ticks_ff;
   logic        long_en_ff;

   logic        stable_ff, stable_in;
   logic [15:0] deb_cnt_ff, deb_cnt_in;
   logic [7:0]  hold_ff, hold_in;
   logic [7:0]  cycle_ff, cycle_in;
   phase_type   phase_ff, phase_in;
   event_type   event_ff, event_in;

   logic [15:0] deb_limit, long_limit, deb_inc;
   logic        csr_write, req_accept;
   logic [1:0]  reg_index;
   rsp_type     step_rsp, head_rsp;

   assign pready     = 1'b1;
   assign reg_index  = paddr[3:2];
   assign csr_write  = psel && penable && pwrite && pready;
   assign req_accept = req_valid && !req_stall;

   assign deb_limit  = (deb_ticks_ff != '0) ? deb_ticks_ff : DEFAULT_DEBOUNCE;
   assign long_limit = (long_ticks_ff != '0) ? long_ticks_ff : {8'd0, LONG_REPEAT};
   assign deb_inc    = deb_cnt_ff + 16'd1;

   always_comb begin
      unique case (reg_index)
         REG_TRIGGER_LEVEL:  prdata = {31'd0, trigger_ff};
         REG_DEBOUNCE_TICKS: prdata = {16'd0, deb_ticks_ff};
         REG_LONG_TICKS:     prdata = {16'd0, long_ticks_ff};
         REG_LONG_ENABLED:   prdata = {31'd0, long_en_ff};
         default:            prdata = '0;
      endcase
   end

   always_comb begin
      stable_in = stable_ff;
      deb_cnt_in = deb_cnt_ff;
      hold_in = hold_ff;
      cycle_in = cycle_ff;
      phase_in = phase_ff;
      event_in = event_ff;
      step_rsp = '0;

      // debounce: accept a changed level once it has persisted long enough
      if (req_level != stable_ff) begin
         if (deb_inc >= deb_limit) begin
            stable_in = req_level;
            deb_cnt_in = '0;
            hold_in = '0;
            cycle_in = '0;
            if (req_level == trigger_ff) begin
               phase_in = PH_PRESSED;
            end else begin
               phase_in = PH_RELEASED;
               step_rsp.up_event = 1'b1;
            end
         end else begin
            deb_cnt_in = deb_inc;
         end
      end else begin
         deb_cnt_in = '0;
      end

      // phase handling sees the level accepted in this same tick
      unique case (phase_in)
         PH_PRESSED: begin
            if (stable_in == trigger_ff) begin
               event_in = EV_PRESS;
               hold_in = hold_in + 8'd1;
               if ({8'd0, hold_in} >= long_limit) begin
                  cycle_in = cycle_in + 8'd1;
                  if (cycle_in >= LONG_REPEAT) begin
                     cycle_in = '0;
                     if (long_en_ff) begin
                        event_in = EV_LONG;
                        step_rsp.long_event = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  if (hold_in == HOLD_TOP) begin
                     hold_in = HOLD_RESTART;
                  end
               end
            end
         end
         PH_RELEASED: begin
            if (event_ff == EV_PRESS) begin
               hold_in = '0;
               step_rsp.click_event = 1'b1;
               phase_in = PH_IDLE;
            end else if (event_ff == EV_LONG) begin
               hold_in = '0;
               step_rsp.long_release_event = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            hold_in = '0;
            cycle_in = '0;
         end
      endcase

      step_rsp.button_phase = phase_in;
      step_rsp.last_event = event_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ff    <= 1'b0;
         deb_ticks_ff  <= '0;
         long_ticks_ff <= '0;
         long_en_ff    <= 1'b0;
         stable_ff     <= 1'b1;
         deb_cnt_ff    <= '0;
         hold_ff       <= '0;
         cycle_ff      <= '0;
         phase_ff      <= PH_IDLE;
         event_ff      <= EV_NONE;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_TRIGGER_LEVEL: begin
               trigger_ff <= pwdata[0];
               stable_ff  <= ~pwdata[0];
            end
            REG_DEBOUNCE_TICKS: deb_ticks_ff  <= pwdata[15:0];
            REG_LONG_TICKS:     long_ticks_ff <= pwdata[15:0];
            REG_LONG_ENABLED:   long_en_ff    <= pwdata[0];
            default: ;
         endcase
      end else if (req_accept) begin
         stable_ff  <= stable_in;
         deb_cnt_ff <= deb_cnt_in;
         hold_ff    <= hold_in;
         cycle_ff   <= cycle_in;
         phase_ff   <= phase_in;
         event_ff   <= event_in;
      end
   end

   bde_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (step_rsp),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head_rsp)
   );

   assign rsp_up_event           = head_rsp.up_event;
   assign rsp_click_event        = head_rsp.click_event;
   assign rsp_long_event         = head_rsp.long_event;
   assign rsp_long_release_event = head_rsp.long_release_event;
   assign rsp_button_phase       = head_rsp.button_phase;
   assign rsp_last_event         = head_rsp.last_event;

endmodule

>>> rtl/bde_checker.sv
module bde_checker
   import bde_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_up_event,
   input logic       rsp_click_event,
   input logic       rsp_long_event,
   input logic       rsp_long_release_event,
   input logic [1:0] rsp_button_phase,
   input logic [1:0] rsp_last_event
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   // a long event ends the press: idle phase, long code
   a_long_ends_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_long_event |->
         rsp_button_phase == PH_IDLE && rsp_last_event == EV_LONG &&
         !rsp_up_event && !rsp_click_event && !rsp_long_release_event)
      else $error("long event with inconsistent phase or flags");

   // release outcomes only come with the up event and return to idle
   a_release_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_click_event || rsp_long_release_event) |->
         rsp_button_phase == PH_IDLE &&
         !(rsp_click_event && rsp_long_release_event))
      else $error("click and long release inconsistent");

   a_click_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_click_event |-> rsp_last_event == EV_PRESS)
      else $error("click without press code");

endmodule

bind button_debounce_event_detector bde_checker u_bde_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_up_event           (rsp_up_event),
   .rsp_click_event        (rsp_click_event),
   .rsp_long_event         (rsp_long_event),
   .rsp_long_release_event (rsp_long_release_event),
   .rsp_button_phase       (rsp_button_phase),
   .rsp_last_event         (rsp_last_event)
);
